// ===== src/shds_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package shds_pkg;

    // fixed field widths
    localparam int TGT_W    = 6;
    localparam int POS_W    = 9;
    localparam int MAG_W    = 9;
    localparam int DLEN_W   = 10;
    localparam int SCORE_W  = 16;
    localparam int COUNT_W  = 12;
    localparam int CID_W    = 17;

    // stream widths
    localparam int S_TDATA_W = 72;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 64;
    localparam int M_TUSER_W = 1;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED_LEN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_CAND = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TBASE    = 2'd2;

    // item kinds
    localparam logic [1:0] OP_HIT   = 2'd0;
    localparam logic [1:0] OP_SCORE = 2'd1;
    localparam logic [1:0] OP_START = 2'd2;

    // queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;

    typedef struct packed {
        logic [2:0]  seed_len;
        logic [10:0] max_cand;
        logic [15:0] tbase;
    } t_cfg;

    typedef struct packed {
        logic [1:0]         op;
        logic [TGT_W-1:0]   tgt;
        logic               tgt_ok;
        logic [CID_W-1:0]   cid;
        logic               diff_neg;
        logic [MAG_W-1:0]   diff_mag;
        logic [DLEN_W-1:0]  dlen;
        logic               dlen_ok;
        logic [SCORE_W-1:0] prior_min;
        logic [COUNT_W-1:0] prior_count;
    } t_job;

    typedef struct packed {
        logic               admitted;
        logic [CID_W-1:0]   cid;
        logic [SCORE_W-1:0] score;
        logic [SCORE_W-1:0] running_min;
        logic [COUNT_W-1:0] cand_count;
    } t_res;

endpackage

`default_nettype wire

// ===== src/shds_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module shds_front #(
    parameter int NUM_TARGETS = 64
) (
    input  wire logic                             i_tvalid,
    output logic                                  o_tready,
    input  wire logic [shds_pkg::S_TDATA_W-1:0]   i_tdata,
    input  wire logic [shds_pkg::S_TUSER_W-1:0]   i_tuser,
    input  wire shds_pkg::t_cfg                   i_cfg,
    input  wire logic                             i_full,
    input  wire logic                             i_hold,
    output logic                                  o_push,
    output shds_pkg::t_job                        o_job
);
    import shds_pkg::*;

    logic [TGT_W-1:0]   tgt;
    logic [POS_W-1:0]   tpos;
    logic [POS_W-1:0]   qpos;
    logic [POS_W-1:0]   qlen;
    logic [POS_W-1:0]   tlen;
    logic [11:0]        dlen_s;
    logic               is_target_op;

    // unpack the request
    assign tgt  = i_tdata[5:0];
    assign tpos = i_tdata[14:6];
    assign qpos = i_tdata[23:15];
    assign qlen = i_tdata[32:24];
    assign tlen = i_tdata[41:33];

    // handshake: stall on a full queue or while memories are swept
    assign o_tready = !i_full && !i_hold;
    assign o_push   = i_tvalid && o_tready;

    // diagonal range length, may go negative for short sequences
    assign dlen_s = 12'(qlen) + 12'(tlen) + 12'd1 - 12'({i_cfg.seed_len, 1'b0});

    assign is_target_op = (i_tuser == OP_HIT) || (i_tuser == OP_SCORE);

    // classify and precompute per-item values
    always_comb begin
        o_job.op          = i_tuser;
        o_job.tgt         = tgt;
        o_job.tgt_ok      = 32'(tgt) < 32'(NUM_TARGETS);
        o_job.cid         = is_target_op ? (CID_W'(i_cfg.tbase) + CID_W'(tgt)) : '0;
        o_job.diff_neg    = tpos < qpos;
        o_job.diff_mag    = (tpos < qpos) ? (qpos - tpos) : (tpos - qpos);
        o_job.dlen        = dlen_s[DLEN_W-1:0];
        o_job.dlen_ok     = !dlen_s[11] && (dlen_s != 12'd0);
        o_job.prior_min   = i_tdata[57:42];
        o_job.prior_count = i_tdata[69:58];
    end

endmodule

`default_nettype wire

// ===== src/shds_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

module shds_fifo (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire shds_pkg::t_job i_job,
    output logic                o_full,
    input  wire logic           i_pop,
    output logic                o_valid,
    output shds_pkg::t_job      o_job
);
    import shds_pkg::*;

    t_job                 r_slot [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr;
    logic [Q_PTR_W-1:0]   r_rd;
    logic [Q_PTR_W:0]     r_cnt;

    assign o_full  = r_cnt == (Q_PTR_W + 1)'(Q_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_job   = r_slot[r_rd];

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_job;
        end
    end

endmodule

`default_nettype wire

// ===== src/shds_rem.sv =====
`timescale 1ns / 1ps
`default_nettype none

module shds_rem (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [shds_pkg::MAG_W-1:0]   i_num,
    input  wire logic [shds_pkg::DLEN_W-1:0]  i_den,
    output logic                              o_done,
    output logic [shds_pkg::MAG_W-1:0]        o_rem
);
    import shds_pkg::*;

    logic                r_busy;
    logic                r_done;
    logic [3:0]          r_cnt;
    logic [MAG_W-1:0]    r_num;
    logic [MAG_W-1:0]    r_rem;
    logic [DLEN_W-1:0]   r_den;
    logic [MAG_W:0]      trial;
    logic [MAG_W-1:0]    n_rem;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    assign trial = {r_rem, r_num[MAG_W-1]};
    assign n_rem = (trial >= (MAG_W + 1)'(r_den)) ?
                   MAG_W'(trial - (MAG_W + 1)'(r_den)) : MAG_W'(trial);

    assign o_done = r_done;
    assign o_rem  = r_rem;

    // step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 4'(MAG_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == 4'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[MAG_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

endmodule

`default_nettype wire

// ===== src/shds_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module shds_back #(
    parameter int NUM_TARGETS = 64,
    parameter int DIAG_DEPTH  = 1024
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_q_valid,
    input  wire shds_pkg::t_job i_q_job,
    output logic                o_q_pop,
    input  wire shds_pkg::t_cfg i_cfg,
    input  wire logic           i_m_ready,
    output logic                o_m_valid,
    output shds_pkg::t_res      o_res,
    output logic                o_sweep
);
    import shds_pkg::*;

    localparam int DEPTH = NUM_TARGETS * DIAG_DEPTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int TW    = (NUM_TARGETS > 1) ? $clog2(NUM_TARGETS) : 1;
    localparam int KW    = $clog2(DIAG_DEPTH);
    localparam int SH    = DLEN_W + KW;
    localparam int RECIP = ((1 << SH) + DIAG_DEPTH - 1) / DIAG_DEPTH;
    localparam int RW    = DLEN_W + 2;
    localparam int PW    = DLEN_W + RW;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_RED   = 3'd3;
    localparam logic [2:0] S_RD    = 3'd4;
    localparam logic [2:0] S_UPD   = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0]          r_state;
    logic [AW-1:0]       r_swp;
    logic                r_emit;
    t_job                r_job;
    logic [DLEN_W-1:0]   r_d;
    logic [DLEN_W-1:0]   r_q;
    logic [AW-1:0]       r_addr;
    logic                r_adm;
    logic [SCORE_W-1:0]  r_score;
    logic [SCORE_W-1:0]  r_thr;
    logic [COUNT_W-1:0]  r_held;
    logic                r_ov;
    t_res                r_out;

    logic [SCORE_W-1:0]  r_cnt_mem [DEPTH];
    logic [SCORE_W-1:0]  r_max_mem [NUM_TARGETS];
    logic [SCORE_W-1:0]  r_cnt_rd;
    logic [SCORE_W-1:0]  r_max_rd;

    logic                rem_start;
    logic                rem_done;
    logic [MAG_W-1:0]    rem_val;
    logic [DLEN_W-1:0]   d_fix;
    logic [PW-1:0]       prod;
    logic [31:0]         slot_w;
    logic [31:0]         slot_c;
    logic [31:0]         addr_w;
    logic [31:0]         tgt_w;
    logic [TW-1:0]       tgt_idx;
    logic [AW-1:0]       rd_addr;
    logic                swp_last;
    logic [SCORE_W-1:0]  cnt_inc;
    logic                admit;
    logic                out_free;
    logic                cnt_we;
    logic [AW-1:0]       cnt_waddr;
    logic [SCORE_W-1:0]  cnt_wdata;
    logic                max_we;
    logic [TW-1:0]       max_widx;
    logic [SCORE_W-1:0]  max_wdata;

    assign o_sweep   = r_state == S_CLEAR;
    assign o_q_pop   = (r_state == S_IDLE) && i_q_valid;
    assign o_m_valid = r_ov;
    assign o_res     = r_out;
    assign out_free  = !r_ov || i_m_ready;
    assign swp_last  = r_swp == AW'(DEPTH - 1);

    // start the remainder unit straight from the queue head
    assign rem_start = o_q_pop && (i_q_job.op == OP_HIT) && i_q_job.tgt_ok && i_q_job.dlen_ok;

    shds_rem u_rem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (rem_start),
        .i_num   (i_q_job.diff_mag),
        .i_den   (i_q_job.dlen),
        .o_done  (rem_done),
        .o_rem   (rem_val)
    );

    // true modulo: a negative difference folds back into the range
    assign d_fix = (r_job.diff_neg && (rem_val != '0)) ?
                   (r_job.dlen - DLEN_W'(rem_val)) : DLEN_W'(rem_val);

    // slot = d mod DIAG_DEPTH through a reciprocal multiply and one correction
    assign prod   = PW'(r_d) * PW'(RW'(RECIP));
    assign slot_w = 32'(r_d) - 32'(r_q) * 32'(DIAG_DEPTH);
    assign slot_c = (slot_w >= 32'(DIAG_DEPTH)) ? (slot_w - 32'(DIAG_DEPTH)) : slot_w;

    assign tgt_w   = 32'(r_job.tgt);
    assign tgt_idx = tgt_w[TW-1:0];
    assign addr_w  = 32'(tgt_idx) * 32'(DIAG_DEPTH) + 32'(slot_c[KW-1:0]);
    assign rd_addr = addr_w[AW-1:0];

    // counter update and admission decision
    assign cnt_inc = (r_cnt_rd == '1) ? r_cnt_rd : (r_cnt_rd + 1'b1);
    assign admit   = (r_held < COUNT_W'(i_cfg.max_cand)) || (r_max_rd > r_thr);

    // memory write port selection
    always_comb begin
        cnt_we    = 1'b0;
        cnt_waddr = r_addr;
        cnt_wdata = cnt_inc;
        max_we    = 1'b0;
        max_widx  = tgt_idx;
        max_wdata = cnt_inc;
        if (r_state == S_CLEAR) begin
            cnt_we    = 1'b1;
            cnt_waddr = r_swp;
            cnt_wdata = '0;
            max_we    = 32'(r_swp) < 32'(NUM_TARGETS);
            max_widx  = r_swp[TW-1:0];
            max_wdata = '0;
        end else if ((r_state == S_UPD) && (r_job.op == OP_HIT)) begin
            cnt_we = 1'b1;
            max_we = cnt_inc > r_max_rd;
        end
    end

    // diagonal counters and per-target maxima
    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            r_cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        if (max_we) begin
            r_max_mem[max_widx] <= max_wdata;
        end
        if (r_state == S_RD) begin
            r_cnt_rd <= r_cnt_mem[rd_addr];
            r_max_rd <= r_max_mem[tgt_idx];
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_swp   <= '0;
            r_emit  <= 1'b0;
            r_thr   <= '1;
            r_held  <= '0;
        end else begin
            case (r_state)
                S_CLEAR: begin
                    r_swp <= r_swp + 1'b1;
                    if (swp_last) begin
                        r_swp   <= '0;
                        r_emit  <= 1'b0;
                        r_state <= r_emit ? S_DONE : S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_q_valid) begin
                        case (i_q_job.op)
                            OP_HIT: begin
                                r_state <= (i_q_job.tgt_ok && i_q_job.dlen_ok) ? S_DIV : S_DONE;
                            end
                            OP_SCORE: begin
                                r_state <= i_q_job.tgt_ok ? S_RD : S_DONE;
                            end
                            OP_START: begin
                                r_thr   <= i_q_job.prior_min;
                                r_held  <= i_q_job.prior_count;
                                r_emit  <= 1'b1;
                                r_state <= S_CLEAR;
                            end
                            default: begin
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                S_DIV: begin
                    if (rem_done) begin
                        r_state <= S_RED;
                    end
                end
                S_RED: begin
                    r_state <= S_RD;
                end
                S_RD: begin
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    if ((r_job.op == OP_SCORE) && admit) begin
                        if (r_held != '1) begin
                            r_held <= r_held + 1'b1;
                        end
                        if (r_max_rd < r_thr) begin
                            r_thr <= r_max_rd;
                        end
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // item payload through the sequence
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_job   <= i_q_job;
            r_adm   <= 1'b0;
            r_score <= '0;
        end
        if ((r_state == S_DIV) && rem_done) begin
            r_d <= d_fix;
        end
        if (r_state == S_RED) begin
            r_q <= DLEN_W'(prod >> SH);
        end
        if (r_state == S_RD) begin
            r_addr <= rd_addr;
        end
        if (r_state == S_UPD) begin
            if (r_job.op == OP_HIT) begin
                r_score <= cnt_inc;
            end else begin
                r_score <= r_max_rd;
                r_adm   <= admit;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if ((r_state == S_DONE) && out_free) begin
            r_ov <= 1'b1;
        end else if (i_m_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_DONE) && out_free) begin
            r_out.admitted    <= r_adm;
            r_out.cid         <= r_job.cid;
            r_out.score       <= r_score;
            r_out.running_min <= r_thr;
            r_out.cand_count  <= r_held;
        end
    end

endmodule

`default_nettype wire

// ===== src/seed_hit_diagonal_scorer_top.sv =====
// hit path: a seed hit runs through the 9-step remainder unit for the wrapped diagonal
//   before its counter update; a score request skips the remainder unit
// requests: one at a time in the back end, each finished before the next is taken;
//   a start query sweeps NUM_TARGETS*DIAG_DEPTH counter entries
// reset: synchronous, active low; afterwards the counter memory is cleared in a pass
//   over NUM_TARGETS*DIAG_DEPTH entries during which s_tready stays low
`timescale 1ns / 1ps
`default_nettype none

module seed_hit_diagonal_scorer_top #(
    parameter int NUM_TARGETS = 64,
    parameter int DIAG_DEPTH  = 1024
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // target, target_pos, query_pos, query_len, target_len, prior_min, prior_count
    input  wire logic [shds_pkg::S_TDATA_W-1:0]    s_tdata,
    // op
    input  wire logic [shds_pkg::S_TUSER_W-1:0]    s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // candidate_id, score, running_min, cand_count
    output logic [shds_pkg::M_TDATA_W-1:0]         m_tdata,
    // admitted
    output logic [shds_pkg::M_TUSER_W-1:0]         m_tuser,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [shds_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [shds_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import shds_pkg::*;

    t_cfg  r_cfg;
    t_job  push_job;
    t_job  head_job;
    t_res  res;
    logic  push;
    logic  pop;
    logic  full;
    logic  head_valid;
    logic  sweep;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.seed_len <= 3'd3;
            r_cfg.max_cand <= 11'd100;
            r_cfg.tbase    <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SEED_LEN: r_cfg.seed_len <= i_cfg_data[2:0];
                CFG_MAX_CAND: r_cfg.max_cand <= i_cfg_data[10:0];
                CFG_TBASE:    r_cfg.tbase    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // front: accept and classify
    shds_front #(
        .NUM_TARGETS (NUM_TARGETS)
    ) u_front (
        .i_tvalid (s_tvalid),
        .o_tready (s_tready),
        .i_tdata  (s_tdata),
        .i_tuser  (s_tuser),
        .i_cfg    (r_cfg),
        .i_full   (full),
        .i_hold   (sweep),
        .o_push   (push),
        .o_job    (push_job)
    );

    // queue between front and back
    shds_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (head_valid),
        .o_job   (head_job)
    );

    // back: counters, maxima and admission
    shds_back #(
        .NUM_TARGETS (NUM_TARGETS),
        .DIAG_DEPTH  (DIAG_DEPTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (head_valid),
        .i_q_job   (head_job),
        .o_q_pop   (pop),
        .i_cfg     (r_cfg),
        .i_m_ready (m_tready),
        .o_m_valid (m_tvalid),
        .o_res     (res),
        .o_sweep   (sweep)
    );

    // result packing
    assign m_tdata = {3'b000, res.cand_count, res.running_min, res.score, res.cid};
    assign m_tuser = res.admitted;

endmodule

`default_nettype wire

// ===== src/shds_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module shds_checker (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              s_tvalid,
    input  wire logic                              s_tready,
    input  wire logic [shds_pkg::S_TDATA_W-1:0]    s_tdata,
    input  wire logic [shds_pkg::S_TUSER_W-1:0]    s_tuser,
    input  wire logic                              m_tvalid,
    input  wire logic                              m_tready,
    input  wire logic [shds_pkg::M_TDATA_W-1:0]    m_tdata,
    input  wire logic [shds_pkg::M_TUSER_W-1:0]    m_tuser
);
    import shds_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // an admitted target lowers the threshold to at most its score
    a_adm_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata[48:33] <= m_tdata[32:17])
        else $error("threshold above admitted score");

    // an admission leaves at least one candidate held
    a_adm_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata[60:49] != 12'd0)
        else $error("admission with empty candidate count");

    // no request taken when reset is released, as the memory sweep then runs
    a_init_sweep: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !s_tready)
        else $error("request taken during reset sweep");

endmodule

bind seed_hit_diagonal_scorer_top shds_checker u_shds_checker (.*);

`default_nettype wire

// ===== sim/tb_seed_hit_diagonal_scorer_top.sv =====
`timescale 1ns / 1ps

module tb_seed_hit_diagonal_scorer_top;

    import shds_pkg::*;

    localparam int NUM_TGT        = 64;
    localparam int DIAG_SLOTS     = 1024;
    localparam int CYCLE_LIMIT    = 3_000_000;
    localparam int SETTLE_CYCLES  = 30;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int MAX_PRINTS     = 40;
    // op code the block must pass through untouched
    localparam logic [1:0] OP_NONE = 2'd3;

    typedef struct {
        logic [1:0]  op;
        logic [5:0]  tgt;
        logic [8:0]  tpos;
        logic [8:0]  qpos;
        logic [8:0]  qlen;
        logic [8:0]  tlen;
        logic [15:0] pmin;
        logic [11:0] pcnt;
    } scan_req_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic [S_TUSER_W-1:0]  s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [M_TUSER_W-1:0]  m_tuser;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    seed_hit_diagonal_scorer_top #(
        .NUM_TARGETS (NUM_TGT),
        .DIAG_DEPTH  (DIAG_SLOTS)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // mirror of the scorer state
    logic [2:0]  cur_seed_len = 3'd3;
    logic [10:0] cur_max_cand = 11'd100;
    logic [15:0] cur_tbase    = 16'd0;
    logic [15:0] diag_tally [0:NUM_TGT*DIAG_SLOTS-1];
    logic [15:0] tgt_best   [0:NUM_TGT-1];
    logic [15:0] run_min    = 16'hFFFF;
    logic [11:0] held_cnt   = 12'd0;

    t_res pending_outcomes[$];

    int  mismatches = 0;
    int  results_seen = 0;
    int  cycle_count = 0;
    int  n_hits = 0;
    int  n_scores = 0;
    int  n_admits = 0;
    int  n_starts = 0;
    int  n_none = 0;
    int  rx_wait = 0;
    bit  tx_gaps = 1'b1;
    bit  rx_gaps = 1'b1;
    logic rx_holding = 1'b0;
    event rx_hold_trig;

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_outcomes.size());
            $display("seed_hit_diagonal_scorer_top verification failed");
            $finish;
        end
    end

    function automatic void clear_tallies();
        for (int i = 0; i < NUM_TGT*DIAG_SLOTS; i++) diag_tally[i] = '0;
        for (int i = 0; i < NUM_TGT; i++) tgt_best[i] = '0;
    endfunction

    // expected outcome of one request, updating the mirrored state
    function automatic void tally_request(input scan_req_t r);
        t_res        res;
        int          span;
        int          d;
        int          slot;
        logic [15:0] c;
        res = '0;
        case (r.op)
            OP_HIT: begin
                n_hits++;
                res.cid = {1'b0, cur_tbase} + r.tgt;
                span = int'(r.qlen) + int'(r.tlen) - 2 * int'(cur_seed_len) + 1;
                if (span > 0) begin
                    d = (int'(r.tpos) - int'(r.qpos)) % span;
                    if (d < 0) d += span;
                    slot = int'(r.tgt) * DIAG_SLOTS + d % DIAG_SLOTS;
                    c = diag_tally[slot];
                    if (c != 16'hFFFF) c++;
                    diag_tally[slot] = c;
                    if (c > tgt_best[r.tgt]) tgt_best[r.tgt] = c;
                    res.score = c;
                end
            end
            OP_SCORE: begin
                n_scores++;
                res.cid = {1'b0, cur_tbase} + r.tgt;
                res.score = tgt_best[r.tgt];
                if (held_cnt < {1'b0, cur_max_cand} || res.score > run_min) begin
                    res.admitted = 1'b1;
                    n_admits++;
                    if (held_cnt != 12'hFFF) held_cnt++;
                    if (res.score < run_min) run_min = res.score;
                end
            end
            OP_START: begin
                n_starts++;
                clear_tallies();
                run_min = r.pmin;
                held_cnt = r.pcnt;
            end
            default: n_none++;
        endcase
        res.running_min = run_min;
        res.cand_count = held_cnt;
        pending_outcomes.push_back(res);
    endfunction

    // fields from the lowest bit up, padded to whole bytes
    function automatic logic [S_TDATA_W-1:0] pack_req(input scan_req_t r);
        return {2'b00, r.pcnt, r.pmin, r.tlen, r.qlen, r.qpos, r.tpos, r.tgt};
    endfunction

    function automatic scan_req_t make_req(input logic [1:0] op, input logic [5:0] tgt,
                                           input logic [8:0] tpos, input logic [8:0] qpos,
                                           input logic [8:0] qlen, input logic [8:0] tlen,
                                           input logic [15:0] pmin, input logic [11:0] pcnt);
        scan_req_t r;
        r.op = op;
        r.tgt = tgt;
        r.tpos = tpos;
        r.qpos = qpos;
        r.qlen = qlen;
        r.tlen = tlen;
        r.pmin = pmin;
        r.pcnt = pcnt;
        return r;
    endfunction

    // random request, mostly hits clustered on a few targets and diagonals
    function automatic scan_req_t random_req(input logic [8:0] qlen_cur,
                                             input logic [8:0] tlen_cur);
        scan_req_t r;
        int        sel;
        r = make_req(OP_HIT, $urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom);
        sel = $urandom_range(0, 99);
        if (sel < 50) begin
            r.tgt = $urandom_range(0, 7);
            r.qlen = qlen_cur;
            r.tlen = tlen_cur;
            r.tpos = r.qpos + 9'($urandom_range(0, 3));
        end else if (sel < 56) begin
            r.qlen = $urandom_range(0, 7);
            r.tlen = $urandom_range(0, 7);
        end else if (sel < 62) begin
            // hits keep their random fields
        end else if (sel < 93) begin
            r.op = OP_SCORE;
            if ($urandom_range(0, 9) < 7) r.tgt = $urandom_range(0, 7);
        end else begin
            r.op = OP_NONE;
        end
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input longint got, input longint want);
        if (mismatches < MAX_PRINTS)
            $display("result %0d: %s got %0d expected %0d", results_seen, what, got, want);
        mismatches++;
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (pending_outcomes.size() == 0) begin
                flag_mismatch("result with nothing pending, cand_count", m_tdata[60:49], 0);
            end else begin
                want = pending_outcomes.pop_front();
                if (m_tuser[0] !== want.admitted)
                    flag_mismatch("admitted", m_tuser[0], want.admitted);
                if (m_tdata[16:0] !== want.cid)
                    flag_mismatch("candidate_id", m_tdata[16:0], want.cid);
                if (m_tdata[32:17] !== want.score)
                    flag_mismatch("score", m_tdata[32:17], want.score);
                if (m_tdata[48:33] !== want.running_min)
                    flag_mismatch("running_min", m_tdata[48:33], want.running_min);
                if (m_tdata[60:49] !== want.cand_count)
                    flag_mismatch("cand_count", m_tdata[60:49], want.cand_count);
            end
            results_seen++;
        end
    end

    // result receiver with random stalls
    always @(posedge i_clk) begin
        if (rx_holding) begin
            m_tready <= 1'b0;
        end else if (m_tvalid && m_tready) begin
            rx_wait = rx_gaps ? $urandom_range(0, 7) : 0;
            m_tready <= (rx_wait == 0);
        end else if (rx_wait > 0) begin
            rx_wait--;
            m_tready <= (rx_wait == 0);
        end else begin
            m_tready <= rx_gaps ? ($urandom_range(0, 3) != 0) : 1'b1;
        end
    end

    // long receiver hold-off
    always begin
        @(rx_hold_trig);
        @(posedge i_clk);
        rx_holding <= 1'b1;
        repeat (RX_HOLD_CYCLES) @(posedge i_clk);
        rx_holding <= 1'b0;
    end

    task automatic send_req(input scan_req_t r);
        int gap;
        gap = tx_gaps ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= pack_req(r);
        s_tuser <= r.op;
        do @(posedge i_clk); while (!s_tready);
        tally_request(r);
    endtask

    // stop offering and let every pending result come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_settings(input logic [2:0] seed_len, input logic [10:0] max_cand,
                                 input logic [15:0] tbase);
        logic [CFG_IDX_W-1:0]  idx [3];
        logic [CFG_DATA_W-1:0] val [3];
        idx[0] = CFG_SEED_LEN;
        val[0] = {13'd0, seed_len};
        idx[1] = CFG_MAX_CAND;
        val[1] = {5'd0, max_cand};
        idx[2] = CFG_TBASE;
        val[2] = tbase;
        for (int i = 0; i < 3; i++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[i];
            i_cfg_data <= val[i];
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        i_cfg_valid <= 1'b0;
        cur_seed_len = seed_len;
        cur_max_cand = max_cand;
        cur_tbase = tbase;
    endtask

    // reset settings: field extremes, wrapped and empty diagonals, saturating count
    task automatic test_reset_defaults();
        send_req(make_req(OP_HIT, 6'd0, 9'd0, 9'd0, 9'd511, 9'd511, 16'h0, 12'h0));
        send_req(make_req(OP_HIT, 6'd0, 9'd511, 9'd0, 9'd511, 9'd511, 16'hFFFF, 12'hFFF));
        send_req(make_req(OP_HIT, 6'd0, 9'd0, 9'd511, 9'd511, 9'd511, 16'h0, 12'h0));
        send_req(make_req(OP_HIT, 6'd0, 9'd0, 9'd0, 9'd511, 9'd511, 16'h0, 12'h0));
        send_req(make_req(OP_HIT, 6'd63, 9'd5, 9'd3, 9'd3, 9'd3, 16'h0, 12'h0));
        send_req(make_req(OP_HIT, 6'd1, 9'd7, 9'd2, 9'd0, 9'd0, 16'h0, 12'h0));
        send_req(make_req(OP_HIT, 6'd1, 9'd7, 9'd2, 9'd2, 9'd3, 16'h0, 12'h0));
        send_req(make_req(OP_SCORE, 6'd0, 9'd0, 9'd0, 9'd0, 9'd0, 16'h0, 12'h0));
        send_req(make_req(OP_SCORE, 6'd1, 9'd511, 9'd511, 9'd511, 9'd511, 16'h0, 12'h0));
        send_req(make_req(OP_SCORE, 6'd63, 9'd0, 9'd0, 9'd0, 9'd0, 16'h0, 12'h0));
        send_req(make_req(OP_NONE, 6'd63, 9'd511, 9'd511, 9'd511, 9'd511,
                          16'hFFFF, 12'hFFF));
        // candidate count at its ceiling, threshold at zero
        send_req(make_req(OP_START, 6'd0, 9'd0, 9'd0, 9'd0, 9'd0, 16'h0, 12'hFFF));
        send_req(make_req(OP_HIT, 6'd2, 9'd40, 9'd10, 9'd100, 9'd200, 16'h0, 12'h0));
        send_req(make_req(OP_SCORE, 6'd2, 9'd0, 9'd0, 9'd0, 9'd0, 16'h0, 12'h0));
        send_req(make_req(OP_SCORE, 6'd3, 9'd0, 9'd0, 9'd0, 9'd0, 16'h0, 12'h0));
        drain_results();
    endtask

    // seed length 5, single candidate slot, highest target base
    task automatic test_config_extremes();
        load_settings(3'd5, 11'd1, 16'hFFFF);
        send_req(make_req(OP_START, 6'd0, 9'd0, 9'd0, 9'd0, 9'd0, 16'hFFFF, 12'h0));
        send_req(make_req(OP_HIT, 6'd63, 9'd1, 9'd0, 9'd5, 9'd5, 16'h0, 12'h0));
        send_req(make_req(OP_HIT, 6'd63, 9'd1, 9'd0, 9'd4, 9'd5, 16'h0, 12'h0));
        send_req(make_req(OP_SCORE, 6'd63, 9'd0, 9'd0, 9'd0, 9'd0, 16'h0, 12'h0));
        send_req(make_req(OP_SCORE, 6'd10, 9'd0, 9'd0, 9'd0, 9'd0, 16'h0, 12'h0));
        send_req(make_req(OP_HIT, 6'd10, 9'd300, 9'd20, 9'd400, 9'd300, 16'h0, 12'h0));
        send_req(make_req(OP_HIT, 6'd10, 9'd300, 9'd20, 9'd400, 9'd300, 16'h0, 12'h0));
        send_req(make_req(OP_SCORE, 6'd10, 9'd0, 9'd0, 9'd0, 9'd0, 16'h0, 12'h0));
        drain_results();
    endtask

    // one query of random traffic under the given settings
    task automatic test_random_query(input int n_items, input logic [2:0] seed_len,
                                     input logic [10:0] max_cand, input logic [15:0] tbase,
                                     input bit tx_idle, input bit rx_idle);
        logic [8:0]  qlen_cur;
        logic [8:0]  tlen_cur;
        logic [11:0] pcnt;
        int          sel;
        tx_gaps = tx_idle;
        rx_gaps = rx_idle;
        load_settings(seed_len, max_cand, tbase);
        qlen_cur = $urandom_range(60, 511);
        tlen_cur = $urandom_range(60, 511);
        sel = $urandom_range(0, 9);
        if (sel < 4)
            pcnt = (max_cand > 20) ? 12'(max_cand - $urandom_range(0, 20)) : 12'd0;
        else if (sel < 7)
            pcnt = $urandom;
        else
            pcnt = 12'd0;
        send_req(make_req(OP_START, $urandom, $urandom, $urandom, $urandom, $urandom,
                          $urandom_range(0, 20), pcnt));
        for (int i = 0; i < n_items; i++) send_req(random_req(qlen_cur, tlen_cur));
        drain_results();
    endtask

    // receiver holds off while requests keep coming, so the input must stall
    task automatic test_backpressure();
        tx_gaps = 1'b0;
        -> rx_hold_trig;
        for (int i = 0; i < 40; i++)
            send_req(make_req(OP_HIT, 6'($urandom_range(0, 3)), $urandom, $urandom,
                              9'd300, 9'd300, $urandom, $urandom));
        drain_results();
    endtask

    initial begin
        clear_tallies();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_config_extremes();
        test_random_query(400, 3'd4, 11'd2047, $urandom, 1'b1, 1'b1);
        test_backpressure();
        test_random_query(400, 3'd0, 11'd1024, 16'd0, 1'b0, 1'b0);
        test_random_query(400, 3'd7, 11'($urandom_range(1, 16)), $urandom, 1'b0, 1'b1);

        $display("covered %0d hits, %0d score requests (%0d admitted), %0d query starts,",
                 n_hits, n_scores, n_admits, n_starts);
        $display("%0d unknown ops; %0d results checked in %0d cycles, %0d mismatches",
                 n_none, results_seen, cycle_count, mismatches);
        if (mismatches == 0 && pending_outcomes.size() == 0) begin
            $display("seed_hit_diagonal_scorer_top verification clean");
        end else begin
            $display("seed_hit_diagonal_scorer_top verification failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/shds_pkg.sv
src/shds_front.sv
src/shds_fifo.sv
src/shds_rem.sv
src/shds_back.sv
src/seed_hit_diagonal_scorer_top.sv
src/shds_checker.sv
sim/tb_seed_hit_diagonal_scorer_top.sv
